>>> hdl/pei_pkg.sv
// Shared constants, register indexes and the decimal scale table of the packet error injector.
`default_nettype none
package pei_pkg;
	localparam int SETTING_W = 5;
	localparam int PROB_W = 32;
	localparam int BYTES_W = 12;
	localparam int SEED_W = 31;
	localparam int SCALE_W = 30;
	localparam int SCALE_Y_W = 27;

	localparam logic [SEED_W-1:0] MOD_ONE = 31'd2147483563;
	localparam logic [SEED_W-1:0] MOD_TWO = 31'd2147483399;
	localparam logic [SEED_W-1:0] MOD_ONE_LESS = 31'd2147483562;
	localparam logic [15:0] MULT_ONE = 16'd40014;
	localparam logic [15:0] MULT_TWO = 16'd40692;
	// Distance of each modulus below 2^31, used to fold the high part of a product.
	localparam logic [7:0] FOLD_ONE = 8'd85;
	localparam logic [7:0] FOLD_TWO = 8'd249;
	localparam logic [SCALE_Y_W-1:0] SCALE_Y = 27'd100000000;
	localparam logic [SEED_W-1:0] SEED_ONE_RESET = 31'd12345678;
	localparam logic [SEED_W-1:0] SEED_TWO_RESET = 31'd23456789;

	typedef enum logic {
		REG_RATE = 1'b0,
		REG_PROB = 1'b1
	} cfg_reg_t;

	function automatic logic [SCALE_W-1:0] pow_ten(input logic [3:0] k);
		logic [SCALE_W-1:0] v;
		case (k)
			4'd0: v = 30'd1;
			4'd1: v = 30'd10;
			4'd2: v = 30'd100;
			4'd3: v = 30'd1000;
			4'd4: v = 30'd10000;
			4'd5: v = 30'd100000;
			4'd6: v = 30'd1000000;
			4'd7: v = 30'd10000000;
			4'd8: v = 30'd100000000;
			4'd9: v = 30'd1000000000;
			default: v = 30'd1;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

>>> hdl/pei_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none
module pei_mul #(
	parameter int W = 33
) (
	input  wire logic           clk,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic      [2*W-1:0] p
);
	logic [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

>>> hdl/pei_lcg.sv
// Combined multiplicative congruential generator with its two seeds and the difference output.
`default_nettype none
module pei_lcg
	import pei_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              z_load,
	output logic      [SEED_W-1:0] z
);
	logic [SEED_W-1:0] seed_one_q, seed_two_q, z_q;
	logic [SEED_W-1:0] seed_one_nx, seed_two_nx, z_nx;

	// x mod (2^31 - f) = hi*f + lo, which is then below twice the modulus.
	function automatic logic [SEED_W-1:0] fold(input logic [46:0] p, input logic [7:0] f,
			input logic [SEED_W-1:0] m);
		logic [23:0] hf;
		logic [31:0] t;
		hf = 24'(p[46:31]) * 24'(f);
		t = 32'(p[30:0]) + 32'(hf);
		if (t >= 32'(m)) begin
			t = t - 32'(m);
		end
		return t[SEED_W-1:0];
	endfunction

	always_comb begin
		seed_one_nx = fold(47'(seed_one_q) * 47'(MULT_ONE), FOLD_ONE, MOD_ONE);
		seed_two_nx = fold(47'(seed_two_q) * 47'(MULT_TWO), FOLD_TWO, MOD_TWO);
		if (seed_one_q > seed_two_q) begin
			z_nx = seed_one_q - seed_two_q;
		end else begin
			z_nx = MOD_ONE_LESS - (seed_two_q - seed_one_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= SEED_ONE_RESET;
			seed_two_q <= SEED_TWO_RESET;
		end else if (step) begin
			seed_one_q <= seed_one_nx;
			seed_two_q <= seed_two_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (z_load) begin
			z_q <= z_nx;
		end
	end

	assign z = z_q;

	a_seed_one_range: assert property (@(posedge clk) disable iff (!arst_n)
		seed_one_q != '0 && seed_one_q < MOD_ONE)
		else $error("seed one left its range");
	a_seed_two_range: assert property (@(posedge clk) disable iff (!arst_n)
		seed_two_q != '0 && seed_two_q < MOD_TWO)
		else $error("seed two left its range");
endmodule
`default_nettype wire

>>> hdl/packet_error_injector.sv
// Top level of the packet error injector: configuration, sequencer and decision datapath.
`default_nettype none
// Each accepted word carries a packet length and yields one word with the errored flag.
// With a rate setting of 0 (always) or outside 1..9 (never) the answer is ready in the
// cycle after acceptance and the generator keeps its state. Otherwise the block steps
// the combined generator and then works through one shared multiplier and one
// subtractor: setup states that form the 58-bit numerator and the divisor, a bit-serial
// remainder, a power loop over the bits of the bit count (8 times the length) with an
// extra multiply for each set bit, and the final compare. The input is stalled while a
// word is in work or while an answer waits on a stalled output.
module packet_error_injector
	import pei_pkg::*;
#(
	parameter int PACKET_BYTES_MAX = 4095,
	parameter int PROB_FRAC_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTES_W-1:0]   packet_bytes,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      packet_errored,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [PROB_W-1:0]    cfg_data
);
	localparam int F = PROB_FRAC_BITS;
	localparam int QW = F + 1;
	localparam int MW = (QW > 32) ? QW : 32;
	localparam int PW = 2 * MW;
	localparam int EW = (QW > 32) ? QW : 32;
	localparam int BW = $clog2(PACKET_BYTES_MAX + 1);
	localparam int NW = BW + 3;
	localparam int NUMW = SEED_W + SCALE_Y_W;
	localparam int DW = 61;
	localparam int CW = F + DW + 2;
	localparam int CNTW = $clog2(NUMW);
	localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_ZCALC   = 12'b000000000010,
		S_MZY     = 12'b000000000100,
		S_MBM     = 12'b000000001000,
		S_MD      = 12'b000000010000,
		S_MOD     = 12'b000000100000,
		S_PW      = 12'b000001000000,
		S_PW_ACC  = 12'b000010000000,
		S_PW_BASE = 12'b000100000000,
		S_CMP_LO  = 12'b001000000000,
		S_CMP_HI  = 12'b010000000000,
		S_FIN     = 12'b100000000000
	} state_t;

	state_t state_q;
	logic signed [SETTING_W-1:0] setting_q;
	logic [PROB_W-1:0] prob_q;
	logic [NW-1:0] n_q;
	logic [SCALE_W-1:0] scale_q;
	logic [QW-1:0] base_q, acc_q;
	logic [NUMW-1:0] num_q;
	logic [DW-1:0] bm_q, d_q, rem_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0] lo_q;
	logic out_valid_q, errored_q;

	logic [SEED_W-1:0] z;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] p, p_rnd, p_sh;
	logic [QW-1:0] rnd, pep, base_init;
	logic [EW-1:0] eps_ext;
	logic [BW-1:0] bytes_sat;
	logic [DW:0] rem_sh;
	logic [CW-1:0] lhs, rhs;
	logic accept, out_take, out_free, run_mode, decision;
	logic dec_q_use;

	assign accept = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign run_mode = (setting_q >= 5'sd1) && (setting_q <= 5'sd9);

	pei_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept && run_mode),
		.z_load (state_q == S_ZCALC),
		.z      (z)
	);

	pei_mul #(.W(MW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	always_comb begin
		p_rnd = p + (PW'(1) << (F - 1));
		p_sh = p_rnd >> F;
		rnd = p_sh[QW-1:0];
		pep = (acc_q >= ONE_Q) ? '0 : ONE_Q - acc_q;
		eps_ext = EW'(prob_q);
		base_init = (eps_ext >= EW'(ONE_Q)) ? '0 : QW'(EW'(ONE_Q) - eps_ext);
		if (32'(packet_bytes) > 32'(PACKET_BYTES_MAX)) begin
			bytes_sat = BW'(PACKET_BYTES_MAX);
		end else begin
			bytes_sat = BW'(packet_bytes);
		end
		rem_sh = {rem_q, num_q[NUMW-1]};
		// Errored when R * 2^F <= PEP * B * m1; the right side is built from two halves.
		lhs = CW'(rem_q) << F;
		rhs = CW'(lo_q) + (CW'(p) << 32);
		decision = lhs <= rhs;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MZY: begin
				mul_a = MW'(z);
				mul_b = MW'(SCALE_Y);
			end
			S_MBM: begin
				mul_a = MW'(scale_q);
				mul_b = MW'(MOD_ONE);
			end
			S_PW: begin
				mul_a = n_q[0] ? MW'(acc_q) : MW'(base_q);
				mul_b = MW'(base_q);
			end
			S_PW_ACC: begin
				mul_a = MW'(base_q);
				mul_b = MW'(base_q);
			end
			S_CMP_LO: begin
				mul_a = MW'(pep);
				mul_b = MW'(bm_q[31:0]);
			end
			S_CMP_HI: begin
				mul_a = MW'(pep);
				mul_b = MW'(bm_q[DW-1:32]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= -5'sd1;
			prob_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RATE: setting_q <= $signed(cfg_data[SETTING_W-1:0]);
				REG_PROB: prob_q <= cfg_data;
				default: prob_q <= prob_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (run_mode) begin
							state_q <= S_ZCALC;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_ZCALC: state_q <= S_MZY;
				S_MZY: state_q <= S_MBM;
				S_MBM: state_q <= S_MD;
				S_MD: begin
					cnt_q <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(NUMW - 1)) begin
						state_q <= S_PW;
					end
				end
				S_PW: begin
					if (n_q == '0) begin
						state_q <= S_CMP_LO;
					end else if (n_q[0]) begin
						state_q <= S_PW_ACC;
					end else begin
						state_q <= S_PW_BASE;
					end
				end
				S_PW_ACC: state_q <= S_PW_BASE;
				S_PW_BASE: state_q <= S_PW;
				S_CMP_LO: state_q <= S_CMP_HI;
				S_CMP_HI: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					errored_q <= (setting_q == 5'sd0);
					n_q <= {bytes_sat, 3'b000};
					scale_q <= pow_ten(setting_q[3:0]);
					base_q <= base_init;
					acc_q <= ONE_Q;
				end
			end
			S_MBM: num_q <= p[NUMW-1:0];
			S_MD: begin
				bm_q <= p[DW-1:0];
				d_q <= p[DW-1:0] + DW'(MOD_ONE);
				rem_q <= '0;
			end
			S_MOD: begin
				// One restoring step of the remainder by (B+1)*m1 per cycle.
				if (rem_sh >= {1'b0, d_q}) begin
					rem_q <= DW'(rem_sh - {1'b0, d_q});
				end else begin
					rem_q <= rem_sh[DW-1:0];
				end
				num_q <= num_q << 1;
			end
			S_PW_ACC: acc_q <= rnd;
			S_PW_BASE: begin
				base_q <= rnd;
				n_q <= n_q >> 1;
			end
			S_CMP_HI: lo_q <= p;
			S_FIN: begin
				if (out_free) begin
					errored_q <= dec_q_use;
				end
			end
			default: errored_q <= errored_q;
		endcase
	end

	// The high partial product arrives in the first cycle of S_FIN; the decision is taken there.
	always_comb begin
		packet_errored = errored_q;
		out_valid = out_valid_q;
	end

	logic fin_first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_first_q <= 1'b0;
		end else begin
			fin_first_q <= (state_q == S_CMP_HI);
		end
	end

	logic dec_hold_q;
	always_ff @(posedge clk) begin
		if (fin_first_q) begin
			dec_hold_q <= decision;
		end
	end

	assign dec_q_use = fin_first_q ? decision : dec_hold_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD |-> rem_q < d_q)
		else $error("remainder reached the divisor");
	a_power_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PW |-> (acc_q <= ONE_Q && base_q <= ONE_Q))
		else $error("power loop operand above one");
endmodule
`default_nettype wire
